// ----- design/lrupr_pkg.sv -----
// shared constants for the lru page replacement unit
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int PAGE_W    = 16;   // page number field
    localparam int FIDX_W    = 3;    // frame index field
    localparam int FAULT_W   = 32;   // fault counter field
    localparam int CFG_W     = 4;    // frames_in_use register field
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    // register map, word index into the apb space
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

endpackage

// ----- design/lru_page_replacement_unit.sv -----
// lru page replacement unit: fully associative frame set with rank-order recency
`timescale 1ns / 1ps

// Takes one page reference per item and returns one result per item. An item sits in an
// input register, where all active frames are tag-compared in parallel and the hit, fill
// or eviction together with the recency rank update is settled combinationally; the result
// then waits in an output register. A new item is accepted every cycle while the result
// side is not stalled. The combinational tag compare plus rank update sets that rate.
// Writing frames_in_use (byte address 0) empties all frames but keeps the fault count; a
// reference flagged last_ref empties the frames and clears the count after its result.
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lrupr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lrupr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lrupr_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    // reference channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]    page,
    input  logic                            last_ref,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [lrupr_pkg::FIDX_W-1:0]    frame_index,
    output logic                            evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]    evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]   fault_count
);

    import lrupr_pkg::*;

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int FIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration
    logic [FIM_W-1:0]       fim_reg;
    logic [FIM_W-1:0]       eff_count;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_wr;

    // frame state
    logic [PAGE_W-1:0]      frame_page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  frame_valid_reg;
    logic [RANK_W-1:0]      rank_reg       [MAX_FRAMES];
    logic [FAULT_W-1:0]     faults_reg;

    // input stage
    logic                   in_v_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic                   last_reg;

    // output stage
    logic                   out_v_reg;
    logic                   hit_reg;
    logic [FIDX_W-1:0]      fidx_reg;
    logic                   ev_valid_reg;
    logic [PAGE_W-1:0]      ev_page_reg;
    logic [FAULT_W-1:0]     fault_reg;

    // lookup
    logic [MAX_FRAMES-1:0]  active;
    logic [MAX_FRAMES-1:0]  match;
    logic [MAX_FRAMES-1:0]  empty;
    logic [MAX_FRAMES-1:0]  oldest;
    logic [IDX_W-1:0]       hit_pos;
    logic [IDX_W-1:0]       empty_pos;
    logic [IDX_W-1:0]       lru_pos;
    logic [IDX_W-1:0]       pos;
    logic                   is_hit;
    logic                   found_empty;
    logic [RANK_W-1:0]      hit_age;
    logic [RANK_W-1:0]      top_rank;
    logic                   ev_valid;
    logic [PAGE_W-1:0]      ev_page;
    logic [FAULT_W-1:0]     faults_next;
    logic [RANK_W-1:0]      rank_next      [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  frame_valid_next;
    logic                   proc;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_FRAMES_IN_USE: prdata = PDATA_W'(fim_reg);
            default:           prdata = '0;
        endcase
    end

    // clamp the configured count to 1..MAX_FRAMES
    always_comb
    begin
        if (fim_reg == '0)
            eff_count = FIM_W'(1);
        else if (fim_reg > FIM_W'(MAX_FRAMES))
            eff_count = FIM_W'(MAX_FRAMES);
        else
            eff_count = fim_reg;
    end

    assign top_rank = RANK_W'(eff_count - FIM_W'(1));

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            active[i] = FIM_W'(i) < eff_count;
            match[i]  = active[i] && frame_valid_reg[i] && (frame_page_reg[i] == page_reg);
            empty[i]  = active[i] && !frame_valid_reg[i];
            // frames fill from the bottom, so when full the ranks are a permutation
            oldest[i] = active[i] && (rank_reg[i] == top_rank);
        end
    end

    // lowest index wins
    always_comb
    begin
        hit_pos   = '0;
        empty_pos = '0;
        lru_pos   = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_pos = IDX_W'(i);
            if (empty[i])
                empty_pos = IDX_W'(i);
            if (oldest[i])
                lru_pos = IDX_W'(i);
        end
    end

    assign is_hit      = |match;
    assign found_empty = |empty;
    assign hit_age     = rank_reg[hit_pos];
    assign ev_valid    = !is_hit && !found_empty;
    assign ev_page     = ev_valid ? frame_page_reg[lru_pos] : '0;

    always_comb
    begin
        if (is_hit)
            pos = hit_pos;
        else if (found_empty)
            pos = empty_pos;
        else
            pos = lru_pos;
    end

    assign faults_next = (!is_hit && (faults_reg != '1)) ? faults_reg + FAULT_W'(1)
                                                         : faults_reg;

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (active[i] && frame_valid_reg[i])
            begin
                if (is_hit)
                begin
                    if (rank_reg[i] < hit_age)
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                else if (found_empty || (rank_reg[i] < top_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        rank_next[pos]        = '0;
        frame_valid_next[pos] = 1'b1;
    end

    // handshake
    assign proc      = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall  = in_v_reg && !proc;
    assign out_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fim_reg         <= FIM_W'(MAX_FRAMES);
            frame_valid_reg <= '0;
            faults_reg      <= '0;
            in_v_reg        <= 1'b0;
            out_v_reg       <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_valid && !in_stall)
                in_v_reg <= 1'b1;
            else if (proc)
                in_v_reg <= 1'b0;

            if (proc)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;

            if (cfg_wr && (reg_idx == REG_FRAMES_IN_USE))
            begin
                fim_reg         <= FIM_W'(pwdata[CFG_W-1:0]);
                frame_valid_reg <= '0;
                for (int i = 0; i < MAX_FRAMES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else if (proc)
            begin
                if (last_reg)
                begin
                    // end of string: empty everything once the result is out
                    frame_valid_reg <= '0;
                    faults_reg      <= '0;
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        rank_reg[i] <= '0;
                    end
                end
                else
                begin
                    frame_valid_reg <= frame_valid_next;
                    faults_reg      <= faults_next;
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        rank_reg[i] <= rank_next[i];
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            page_reg <= page;
            last_reg <= last_ref;
        end
        if (proc)
        begin
            if (!is_hit)
                frame_page_reg[pos] <= page_reg;
            hit_reg      <= is_hit;
            fidx_reg     <= FIDX_W'(pos);
            ev_valid_reg <= ev_valid;
            ev_page_reg  <= ev_page;
            fault_reg    <= faults_next;
        end
    end

    assign hit           = hit_reg;
    assign frame_index   = fidx_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_reg;

endmodule
